>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UTXF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define UTXF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UTXF_ASSERT(lbl, prop, msg)
`define UTXF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/utxf_pkg.sv
// ----------------------------------------------------------------------------
// UART transmitter package
// Shared types and constants of the FIFO-fed 8N1 transmitter.
// ----------------------------------------------------------------------------
package utxf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PHASE_START = 4'd0;
  localparam logic [PhaseW-1:0] PHASE_STOP = 4'd9;

  localparam logic [ByteW-1:0] BIT_PERIOD_RST = 8'd10;

  localparam int unsigned RES_TX_LINE = 0;
  localparam int unsigned RES_ACCEPTED = 1;
  localparam int unsigned RES_BUSY = 2;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef struct packed {
    logic pop;
    logic head_next;
  } fifo_ctl_t;

  typedef struct packed {
    logic             full;
    logic             last;
    logic [ByteW-1:0] head_byte;
  } fifo_stat_t;

  typedef struct packed {
    logic sending;
    logic line;
  } tx_stat_t;

endpackage

>>> rtl/utxf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module utxf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/utxf_fifo.sv
// ----------------------------------------------------------------------------
// Transmit FIFO
// Ring pointers over the byte store, with the next byte to send prefetched.
// ----------------------------------------------------------------------------
module utxf_fifo #(
  parameter int unsigned FifoDepth = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [7:0]              wdata_i,
  input  utxf_pkg::fifo_ctl_t     ctl_i,
  output utxf_pkg::fifo_stat_t    stat_o
);
  import utxf_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);

  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, fetch_d;
  logic             byp_q, byp_d;
  logic [ByteW-1:0] byp_data_q, ram_rdata;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d = push_i ? ring_next(wr_q) : wr_q;
    rd_d = ctl_i.pop ? ring_next(rd_q) : rd_q;
    fetch_d = ctl_i.head_next ? rd_d : ring_next(rd_d);
    byp_d = push_i && (wr_q == fetch_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      byp_q <= 1'b0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      byp_q <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata_i;
  end

  utxf_ram #(
    .Width (ByteW),
    .Depth (FifoDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (wr_q),
    .wdata_i (wdata_i),
    .raddr_i (fetch_d),
    .rdata_o (ram_rdata)
  );

  assign stat_o.full = (ring_next(wr_q) == rd_q);
  assign stat_o.last = (ring_next(rd_q) == wr_q);
  assign stat_o.head_byte = byp_q ? byp_data_q : ram_rdata;

endmodule

>>> rtl/utxf_bitgen.sv
// ----------------------------------------------------------------------------
// Bit generator
// Tick counter and bit phase sequencer that drives the serial line.
// ----------------------------------------------------------------------------
module utxf_bitgen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 tick_i,
  input  logic [7:0]           bit_period_i,
  input  utxf_pkg::fifo_stat_t fifo_i,
  output utxf_pkg::fifo_ctl_t  ctl_o,
  output utxf_pkg::tx_stat_t   next_o
);
  import utxf_pkg::*;

  logic              sending_q, sending_d;
  logic              line_q, line_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  tick_q, tick_d, shift_q, shift_d;
  logic [ByteW-1:0]  period, cnt;
  logic [ByteW:0]    cnt_inc;
  logic              pop;

  always_comb begin
    sending_d = sending_q;
    line_d = line_q;
    phase_d = phase_q;
    tick_d = tick_q;
    shift_d = shift_q;
    pop = 1'b0;
    period = (bit_period_i == '0) ? ByteW'(1) : bit_period_i;
    cnt = (tick_q >= period) ? '0 : tick_q;
    cnt_inc = {1'b0, cnt} + (ByteW+1)'(1);
    if (push_i) begin
      sending_d = 1'b1;
    end else if (tick_i && sending_q) begin
      if (cnt == '0) begin
        if (phase_q == PHASE_START) begin
          line_d = 1'b0;
          shift_d = fifo_i.head_byte;
          phase_d = PHASE_START + PhaseW'(1);
        end else if (phase_q < PHASE_STOP) begin
          line_d = shift_q[0];
          shift_d = shift_q >> 1;
          phase_d = phase_q + PhaseW'(1);
        end else if (phase_q == PHASE_STOP) begin
          line_d = 1'b1;
          phase_d = PHASE_STOP + PhaseW'(1);
        end else begin
          pop = 1'b1;
          if (fifo_i.last) begin
            sending_d = 1'b0;
            phase_d = PHASE_START;
            line_d = 1'b1;
          end else begin
            line_d = 1'b0;
            shift_d = fifo_i.head_byte;
            phase_d = PHASE_START + PhaseW'(1);
          end
        end
      end
      tick_d = (!sending_d || cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      line_q <= 1'b1;
      phase_q <= PHASE_START;
      tick_q <= '0;
      shift_q <= '0;
    end else begin
      sending_q <= sending_d;
      line_q <= line_d;
      phase_q <= phase_d;
      tick_q <= tick_d;
      shift_q <= shift_d;
    end
  end

  assign ctl_o.pop = pop;
  assign ctl_o.head_next = (phase_d == PHASE_START);
  assign next_o.sending = sending_d;
  assign next_o.line = line_d;

endmodule

>>> rtl/uart_tx_with_fifo_core.sv
// ----------------------------------------------------------------------------
// UART transmitter with FIFO
// 8N1 serial transmitter fed from a ring FIFO of FifoDepth-1 usable bytes.
// ----------------------------------------------------------------------------
// An accepted item's result stands in the output register in the next cycle.
// Throughput: one item per cycle while the output is not stalled by m_axis_tready; the
// state update is counter compares and a phase step between the input handshake and the result register.
// Reset clears the pointers, the bit sequencer and the output valid flag at once,
// with the line idle high and the bit period at ten ticks; the result data is not reset.
module uart_tx_with_fifo_core #(
  parameter int unsigned FifoDepth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] tx_line, [1] accepted, [2] busy_res
);
  import utxf_pkg::*;

  logic             out_valid_q;
  logic [7:0]       out_data_q, out_data_d;
  logic [ByteW-1:0] bit_period_q;
  logic             in_acc, push, tick;
  fifo_ctl_t        fifo_ctl;
  fifo_stat_t       fifo_stat;
  tx_stat_t         tx_next;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign push = in_acc && (action_e'(s_axis_tuser) == ACT_WRITE) && !fifo_stat.full;
  assign tick = in_acc && (action_e'(s_axis_tuser) == ACT_TICK);

  utxf_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (s_axis_tdata),
    .ctl_i   (fifo_ctl),
    .stat_o  (fifo_stat)
  );

  utxf_bitgen u_bitgen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .tick_i       (tick),
    .bit_period_i (bit_period_q),
    .fifo_i       (fifo_stat),
    .ctl_o        (fifo_ctl),
    .next_o       (tx_next)
  );

  always_comb begin
    out_data_d = '0;
    out_data_d[RES_TX_LINE] = tx_next.line;
    out_data_d[RES_ACCEPTED] = push;
    out_data_d[RES_BUSY] = tx_next.sending;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bit_period_q <= BIT_PERIOD_RST;
    end else begin
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        bit_period_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

`include "assert_macros.svh"

  `UTXF_ASSERT(a_accept_busy, (m_axis_tvalid && m_axis_tdata[RES_ACCEPTED]) |-> m_axis_tdata[RES_BUSY], "accepted write without busy")
  `UTXF_ASSERT(a_idle_line_high, (m_axis_tvalid && !m_axis_tdata[RES_BUSY]) |-> m_axis_tdata[RES_TX_LINE], "line low while idle")
  `UTXF_ASSERT(a_full_refused, (in_acc && s_axis_tuser && fifo_stat.full) |=> !m_axis_tdata[RES_ACCEPTED], "write accepted into full FIFO")
  `UTXF_ASSERT_NEVER(a_push_full, push && fifo_stat.full, "push while FIFO full")

endmodule
